// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 64;

  localparam int REQ_W      = 3;
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 6;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  // cursor and sweep coordinates, wide enough for any register value
  localparam int X_W        = 8;
  localparam int Y_W        = 7;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic [7:0] COLUMNS_RST = 8'd80;
  localparam logic [6:0] ROWS_RST    = 7'd30;
  localparam logic [7:0] ATTR_RST    = 8'd15;

  typedef enum logic [REQ_W-1:0] {
    REQ_PRINT  = 3'd0,
    REQ_SET    = 3'd1,
    REQ_CLEAR  = 3'd2,
    REQ_SCROLL = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_ATTR    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_CLEAR
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_ACCEPT,
    OP_EXEC,
    OP_READ,
    OP_COPY,
    OP_FILL,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             print_scroll;
    logic             pos_ok;
    logic             sweep_last;
    logic             single_row;
  } stat_t;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM, one write and one registered read, write-first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (we && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Request sequencer: reset clear, request decode, scroll and clear sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tcw_pkg::stat_t stat,
  output tcw_pkg::cmd_t  cmd,
  output logic          busy
);

  tcw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = tcw_pkg::OP_NONE;
    cmd.finish = 1'b0;
    busy       = (state != tcw_pkg::ST_IDLE);
    case (state)
      tcw_pkg::ST_INIT: begin
        cmd.op = tcw_pkg::OP_INIT;
        if (stat.sweep_last) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          cmd.op     = tcw_pkg::OP_ACCEPT;
          state_next = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        cmd.op = tcw_pkg::OP_EXEC;
        case (stat.req)
          tcw_pkg::REQ_PRINT: begin
            if (stat.print_scroll) begin
              state_next = stat.single_row ? tcw_pkg::ST_FILL : tcw_pkg::ST_COPY;
            end else begin
              cmd.finish = 1'b1;
              state_next = tcw_pkg::ST_IDLE;
            end
          end
          tcw_pkg::REQ_CLEAR: begin
            state_next = tcw_pkg::ST_CLEAR;
          end
          tcw_pkg::REQ_SCROLL: begin
            state_next = stat.single_row ? tcw_pkg::ST_FILL : tcw_pkg::ST_COPY;
          end
          tcw_pkg::REQ_READ: begin
            if (stat.pos_ok) begin
              state_next = tcw_pkg::ST_READ;
            end else begin
              cmd.finish = 1'b1;
              state_next = tcw_pkg::ST_IDLE;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = tcw_pkg::ST_IDLE;
          end
        endcase
      end
      tcw_pkg::ST_READ: begin
        cmd.op     = tcw_pkg::OP_READ;
        cmd.finish = 1'b1;
        state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_COPY: begin
        cmd.op = tcw_pkg::OP_COPY;
        if (stat.sweep_last) begin
          state_next = tcw_pkg::ST_FILL;
        end
      end
      tcw_pkg::ST_FILL: begin
        cmd.op = tcw_pkg::OP_FILL;
        if (stat.sweep_last) begin
          cmd.finish = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        cmd.op = tcw_pkg::OP_CLEAR;
        if (stat.sweep_last) begin
          cmd.finish = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::ST_INIT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Registers, cursor arithmetic, sweep counters, write stage and screen store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_datapath #(
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tcw_pkg::cmd_t                   cmd,
  output tcw_pkg::stat_t                  stat,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [tcw_pkg::REQ_W-1:0]       req_type,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
  input  logic [tcw_pkg::COL_W-1:0]       col,
  input  logic [tcw_pkg::ROW_W-1:0]       row,
  output logic                            done,
  output logic                            status,
  output logic [tcw_pkg::CHAR_W-1:0]      cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]      cell_attr,
  output logic [tcw_pkg::COL_W-1:0]       cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]       cursor_row
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = tcw_pkg::X_W;
  localparam int YW    = tcw_pkg::Y_W;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y);
    cell_addr = AW'(int'(y) * MAX_COLS + int'(x));
  endfunction

  logic [7:0]                  columns_q;
  logic [6:0]                  rows_q;
  logic [tcw_pkg::ATTR_W-1:0]  attr_q;

  logic [tcw_pkg::REQ_W-1:0]   req_q;
  logic [tcw_pkg::CHAR_W-1:0]  ch_q;
  logic [tcw_pkg::COL_W-1:0]   col_q;
  logic [tcw_pkg::ROW_W-1:0]   row_q;

  logic [XW-1:0] cx, cx_next, sx, x_last;
  logic [YW-1:0] cy, cy_next, sy, y_last;
  logic [XW-1:0] nc, cx_cl, pnx;
  logic [YW-1:0] nr, cy_cl, pny_fix;
  logic [XW:0]   ptx;
  logic [YW:0]   pny;
  logic          is_nl, is_glyph, print_scroll, pos_ok, sweeping, sweep_last;

  logic                       wr_en_q, wr_from_ram_q;
  logic [AW-1:0]              wr_addr_q, rd_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data_q, ram_wdata, rd_data;
  logic                       wr_en_d, wr_from_ram_d;
  logic [AW-1:0]              wr_addr_d;
  logic [tcw_pkg::CELL_W-1:0] wr_data_d;
  logic                       status_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_q <= tcw_pkg::COLUMNS_RST;
      rows_q    <= tcw_pkg::ROWS_RST;
      attr_q    <= tcw_pkg::ATTR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_COLUMNS: columns_q <= cfg_data;
        tcw_pkg::CFG_ROWS:    rows_q    <= cfg_data[6:0];
        tcw_pkg::CFG_ATTR:    attr_q    <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective window
  always_comb begin
    if (columns_q == 8'd0) begin
      nc = 8'd1;
    end else if ({1'b0, columns_q} > 9'(MAX_COLS)) begin
      nc = 8'(MAX_COLS);
    end else begin
      nc = columns_q;
    end
    if (rows_q == 7'd0) begin
      nr = 7'd1;
    end else if ({1'b0, rows_q} > 8'(MAX_ROWS)) begin
      nr = 7'(MAX_ROWS);
    end else begin
      nr = rows_q;
    end
  end

  assign cx_cl  = (cx >= nc) ? nc - 8'd1 : cx;
  assign cy_cl  = (cy >= nr) ? nr - 7'd1 : cy;
  assign pos_ok = ({1'b0, col_q} < nc) && ({1'b0, row_q} < nr);

  // print cursor advance
  assign is_nl    = (ch_q == tcw_pkg::NEWLINE_CODE);
  assign is_glyph = (ch_q != 8'd0) && !is_nl;
  assign ptx      = {1'b0, cx} + 9'd1;

  always_comb begin
    pnx = cx;
    pny = {1'b0, cy};
    if (is_nl) begin
      pnx = 8'd0;
      pny = {1'b0, cy} + 8'd1;
    end else if (is_glyph) begin
      if (ptx >= {1'b0, nc}) begin
        pnx = 8'd0;
        pny = {1'b0, cy} + 8'd1;
      end else begin
        pnx = ptx[XW-1:0];
      end
    end
  end

  assign print_scroll = (pny >= {1'b0, nr});
  assign pny_fix      = print_scroll ? nr - 7'd1 : pny[YW-1:0];

  always_comb begin
    cx_next = cx;
    cy_next = cy;
    case (cmd.op)
      tcw_pkg::OP_ACCEPT: begin
        cx_next = cx_cl;
        cy_next = cy_cl;
      end
      tcw_pkg::OP_EXEC: begin
        case (req_q)
          tcw_pkg::REQ_PRINT: begin
            cx_next = pnx;
            cy_next = pny_fix;
          end
          tcw_pkg::REQ_SET: begin
            if (pos_ok) begin
              cx_next = {1'b0, col_q};
              cy_next = {1'b0, row_q};
            end
          end
          tcw_pkg::REQ_CLEAR: begin
            cx_next = '0;
            cy_next = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // sweep bounds
  always_comb begin
    sweeping = 1'b1;
    x_last   = nc - 8'd1;
    y_last   = nr - 7'd1;
    case (cmd.op)
      tcw_pkg::OP_INIT: begin
        x_last = 8'(MAX_COLS - 1);
        y_last = 7'(MAX_ROWS - 1);
      end
      tcw_pkg::OP_COPY:  y_last = nr - 7'd2;
      tcw_pkg::OP_FILL:  y_last = '0;
      tcw_pkg::OP_CLEAR: ;
      default:           sweeping = 1'b0;
    endcase
  end

  assign sweep_last = (sx == x_last) && (sy == y_last);

  // write stage source
  always_comb begin
    wr_en_d       = 1'b0;
    wr_from_ram_d = 1'b0;
    wr_addr_d     = cell_addr(sx, sy);
    wr_data_d     = {attr_q, 8'd0};
    case (cmd.op)
      tcw_pkg::OP_INIT: begin
        wr_en_d   = 1'b1;
        wr_data_d = '0;
      end
      tcw_pkg::OP_EXEC: begin
        wr_en_d   = (req_q == tcw_pkg::REQ_PRINT) && is_glyph;
        wr_addr_d = cell_addr(cx, cy);
        wr_data_d = {attr_q, ch_q};
      end
      tcw_pkg::OP_COPY: begin
        wr_en_d       = 1'b1;
        wr_from_ram_d = 1'b1;
      end
      tcw_pkg::OP_FILL: begin
        wr_en_d   = 1'b1;
        wr_addr_d = cell_addr(sx, nr - 7'd1);
      end
      tcw_pkg::OP_CLEAR: begin
        wr_en_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign rd_addr = (cmd.op == tcw_pkg::OP_COPY) ? cell_addr(sx, sy + 7'd1)
                                                : cell_addr({1'b0, col_q}, {1'b0, row_q});

  assign status_d = (cmd.op == tcw_pkg::OP_EXEC) && !pos_ok &&
                    ((req_q == tcw_pkg::REQ_SET) || (req_q == tcw_pkg::REQ_READ));

  always_ff @(posedge clk) begin
    if (rst) begin
      cx      <= '0;
      cy      <= '0;
      sx      <= '0;
      sy      <= '0;
      wr_en_q <= 1'b0;
      done    <= 1'b0;
    end else begin
      cx      <= cx_next;
      cy      <= cy_next;
      wr_en_q <= wr_en_d;
      done    <= cmd.finish;
      if (sweeping) begin
        if (sx == x_last) begin
          sx <= '0;
          sy <= (sy == y_last) ? '0 : sy + 7'd1;
        end else begin
          sx <= sx + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_q     <= wr_addr_d;
    wr_data_q     <= wr_data_d;
    wr_from_ram_q <= wr_from_ram_d;
    if (cmd.op == tcw_pkg::OP_ACCEPT) begin
      req_q <= req_type;
      ch_q  <= char_code;
      col_q <= col;
      row_q <= row;
    end
    if (cmd.finish) begin
      status     <= status_d;
      cell_char  <= (cmd.op == tcw_pkg::OP_READ) ? rd_data[7:0] : 8'd0;
      cell_attr  <= (cmd.op == tcw_pkg::OP_READ) ? rd_data[15:8] : 8'd0;
      cursor_col <= cx_next[tcw_pkg::COL_W-1:0];
      cursor_row <= cy_next[tcw_pkg::ROW_W-1:0];
    end
  end

  assign ram_wdata = wr_from_ram_q ? rd_data : wr_data_q;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk     (clk),
    .we      (wr_en_q),
    .wr_addr (wr_addr_q),
    .wr_data (ram_wdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.req          = req_q;
    stat.print_scroll = print_scroll;
    stat.pos_ok       = pos_ok;
    stat.sweep_last   = sweep_last;
    stat.single_row   = (nr == 7'd1);
  end

endmodule

// ===== hw/rtl/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console with cursor, line wrap and scroll.
//
//   channel  ports                                           transfer
//   request  start, busy, req_type, char_code, col, row      start && !busy
//   result   done, status, cell_char, cell_attr,
//            cursor_col, cursor_row                          done
//   config   cfg_we, cfg_index, cfg_data                     cfg_we
//
// Print without scroll, set cursor, bad read and unknown requests finish in
// the execute state; a good read passes through a read state (registered
// screen store read). Clear, scroll and a print that scrolls sweep the
// window one cell per cycle through the store port.
// After reset, clearing all MAX_COLS*MAX_ROWS cells holds busy high.
// Results are a one-cycle done pulse; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_writer_top #(
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [tcw_pkg::REQ_W-1:0]      req_type,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::COL_W-1:0]      col,
  input  logic [tcw_pkg::ROW_W-1:0]      row,
  output logic                           done,
  output logic                           status,
  output logic [tcw_pkg::CHAR_W-1:0]     cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]     cell_attr,
  output logic [tcw_pkg::COL_W-1:0]      cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]      cursor_row,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);

  tcw_pkg::cmd_t  cmd;
  tcw_pkg::stat_t stat;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tcw_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_type   (req_type),
    .char_code  (char_code),
    .col        (col),
    .row        (row),
    .done       (done),
    .status     (status),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
  );

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPLIES(a_done_after_busy, clk, rst, done, $past(busy))
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ASSERT_IMPLIES(a_err_no_cell, clk, rst, done && status, (cell_char == '0) && (cell_attr == '0))

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer. A directed table covers
// window corners, bad positions, wrap, newline, scroll, clear and unknown
// requests. Randomized requests then run over several window geometries and
// attributes. Results are checked field by field against pinned values or a
// behavioral console model that tracks cells, cursor and registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int SCREEN_CELLS = MAX_COLS_DEF * MAX_ROWS_DEF;
  localparam int DRAIN_LIMIT = 50000;
  localparam int PHASES = 8;
  localparam int ERR_PRINT_MAX = 40;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic              status;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
  } console_res_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              pinned;
    console_res_t      want;
  } console_cmd_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [REQ_W-1:0]      req_type;
  logic [CHAR_W-1:0]     char_code;
  logic [COL_W-1:0]      col;
  logic [ROW_W-1:0]      row;
  logic                  done;
  logic                  status;
  logic [CHAR_W-1:0]     cell_char;
  logic [ATTR_W-1:0]     cell_attr;
  logic [COL_W-1:0]      cursor_col;
  logic [ROW_W-1:0]      cursor_row;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [CELL_W-1:0] screen_copy [0:SCREEN_CELLS-1];
  int                track_x;
  int                track_y;
  logic [7:0]        reg_cols;
  logic [6:0]        reg_rows;
  logic [7:0]        reg_attr;

  console_res_t due_results [$];
  console_cmd_t boot_plan [$];

  int n_sent;
  int n_sweeps;
  int n_checked;
  int n_fail;

  int ph_cols  [PHASES] = '{0, 255, 5, 12, 1, 128, 80, 3};
  int ph_rows  [PHASES] = '{0, 127, 3, 7, 64, 1, 30, 2};
  int ph_attr  [PHASES] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h3C, 8'hC3, 8'h0F, 8'h81};
  int ph_idle  [PHASES] = '{0, 0, 56, 13, 0, 56, 13, 0};
  int ph_items [PHASES] = '{60, 40, 300, 300, 100, 100, 100, 200};
  int ph_sweep [PHASES] = '{8, 2, 8, 6, 6, 6, 2, 8};

  text_console_writer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .char_code (char_code),
    .col       (col),
    .row       (row),
    .done      (done),
    .status    (status),
    .cell_char (cell_char),
    .cell_attr (cell_attr),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int window_cols();
    if (reg_cols == 0) return 1;
    if (reg_cols > MAX_COLS_DEF) return MAX_COLS_DEF;
    return reg_cols;
  endfunction

  function automatic int window_rows();
    if (reg_rows == 0) return 1;
    if (reg_rows > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return reg_rows;
  endfunction

  function automatic void shift_window_up(int nc, int nr);
    for (int y = 0; y + 1 < nr; y++)
      for (int x = 0; x < nc; x++)
        screen_copy[y * MAX_COLS_DEF + x] = screen_copy[(y + 1) * MAX_COLS_DEF + x];
    for (int x = 0; x < nc; x++)
      screen_copy[(nr - 1) * MAX_COLS_DEF + x] = {reg_attr, 8'h00};
  endfunction

  function automatic console_res_t console_apply(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch,
                                                 logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
    console_res_t res;
    int nc;
    int nr;
    logic [CELL_W-1:0] v;
    res = '0;
    nc = window_cols();
    nr = window_rows();
    if (track_x >= nc) track_x = nc - 1;
    if (track_y >= nr) track_y = nr - 1;
    case (req)
      REQ_PRINT: begin
        if (ch == NEWLINE_CODE) begin
          track_x = 0;
          track_y++;
        end else if (ch != 0) begin
          screen_copy[track_y * MAX_COLS_DEF + track_x] = {reg_attr, ch};
          track_x++;
          if (track_x >= nc) begin
            track_x = 0;
            track_y++;
          end
        end
        if (track_y >= nr) begin
          track_y = nr - 1;
          shift_window_up(nc, nr);
        end
      end
      REQ_SET: begin
        if (c < nc && r < nr) begin
          track_x = c;
          track_y = r;
        end else begin
          res.status = STATUS_RANGE;
        end
      end
      REQ_CLEAR: begin
        for (int y = 0; y < nr; y++)
          for (int x = 0; x < nc; x++)
            screen_copy[y * MAX_COLS_DEF + x] = {reg_attr, 8'h00};
        track_x = 0;
        track_y = 0;
      end
      REQ_SCROLL: begin
        shift_window_up(nc, nr);
      end
      REQ_READ: begin
        if (c < nc && r < nr) begin
          v = screen_copy[r * MAX_COLS_DEF + c];
          res.cell_char = v[CHAR_W-1:0];
          res.cell_attr = v[CELL_W-1:CHAR_W];
        end else begin
          res.status = STATUS_RANGE;
        end
      end
      default: ;
    endcase
    res.cur_col = COL_W'(track_x);
    res.cur_row = ROW_W'(track_y);
    return res;
  endfunction

  function automatic void plan(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch,
                               logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                               logic pinned, console_res_t want);
    console_cmd_t cmd;
    cmd.req = req;
    cmd.ch = ch;
    cmd.col = c;
    cmd.row = r;
    cmd.pinned = pinned;
    cmd.want = want;
    boot_plan.push_back(cmd);
  endfunction

  function automatic int pick_coord(int n, int field_max);
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 60) return $urandom_range(n - 1, 0);
    if (sel < 75 && n <= field_max) return n;
    return $urandom_range(field_max, 0);
  endfunction

  function automatic console_cmd_t pick_cmd(int sweep_pct);
    console_cmd_t cmd;
    int sel;
    cmd = '0;
    cmd.ch = CHAR_W'($urandom_range(255, 0));
    cmd.col = COL_W'(pick_coord(window_cols(), 127));
    cmd.row = ROW_W'(pick_coord(window_rows(), 63));
    sel = $urandom_range(99, 0);
    if (sel < sweep_pct / 2) begin
      cmd.req = REQ_CLEAR;
    end else if (sel < sweep_pct) begin
      cmd.req = REQ_SCROLL;
    end else if (sel < sweep_pct + 3) begin
      cmd.req = REQ_W'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
    end else if (sel < sweep_pct + 18) begin
      cmd.req = REQ_SET;
    end else if (sel < sweep_pct + 33) begin
      cmd.req = REQ_READ;
    end else begin
      cmd.req = REQ_PRINT;
      sel = $urandom_range(99, 0);
      if (sel < 15) cmd.ch = NEWLINE_CODE;
      else if (sel < 20) cmd.ch = '0;
    end
    return cmd;
  endfunction

  // enter and leave at a falling edge; hold start high until the transfer
  task automatic send(console_cmd_t cmd, int idle_pct);
    console_res_t res;
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req_type <= cmd.req;
    char_code <= cmd.ch;
    col <= cmd.col;
    row <= cmd.row;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = console_apply(cmd.req, cmd.ch, cmd.col, cmd.row);
    due_results.push_back(cmd.pinned ? cmd.want : res);
    n_sent++;
    if (cmd.req == REQ_CLEAR || cmd.req == REQ_SCROLL) n_sweeps++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(posedge clk);
    while ((due_results.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_COLUMNS: reg_cols = data;
      CFG_ROWS:    reg_rows = data[6:0];
      CFG_ATTR:    reg_attr = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      n_fail++;
      if (n_fail <= ERR_PRINT_MAX)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    console_res_t want;
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        n_fail++;
        if (n_fail <= ERR_PRINT_MAX)
          $display("%0t: result with nothing expected, status %0d cursor %0d,%0d",
                   $time, status, cursor_col, cursor_row);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        check_field("status", 8'(want.status), 8'(status));
        check_field("cell_char", want.cell_char, cell_char);
        check_field("cell_attr", want.cell_attr, cell_attr);
        check_field("cursor_col", 8'(want.cur_col), 8'(cursor_col));
        check_field("cursor_row", 8'(want.cur_row), 8'(cursor_row));
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req_type = '0;
    char_code = '0;
    col = '0;
    row = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_sent = 0;
    n_sweeps = 0;
    n_checked = 0;
    n_fail = 0;
    track_x = 0;
    track_y = 0;
    reg_cols = COLUMNS_RST;
    reg_rows = ROWS_RST;
    reg_attr = ATTR_RST;
    for (int i = 0; i < SCREEN_CELLS; i++) screen_copy[i] = '0;

    // after reset: 80 x 30 window, attribute 15, cursor home, blank store
    plan(REQ_READ, 8'h00, 7'd0, 6'd0, 1'b1, {STATUS_OK, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_READ, 8'h00, 7'd79, 6'd29, 1'b1, {STATUS_OK, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_READ, 8'h00, 7'd80, 6'd0, 1'b1, {STATUS_RANGE, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_READ, 8'h00, 7'd0, 6'd30, 1'b1, {STATUS_RANGE, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_READ, 8'hFF, 7'd127, 6'd63, 1'b1, {STATUS_RANGE, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_SET, 8'h00, 7'd127, 6'd63, 1'b1, {STATUS_RANGE, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_SET, 8'h00, 7'd80, 6'd29, 1'b1, {STATUS_RANGE, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_SET, 8'h00, 7'd79, 6'd29, 1'b1, {STATUS_OK, 8'h00, 8'h00, 7'd79, 6'd29});
    plan(REQ_PRINT, 8'h41, 7'd0, 6'd0, 1'b0, '0);
    plan(REQ_READ, 8'h00, 7'd79, 6'd28, 1'b0, '0);
    plan(REQ_PRINT, 8'h00, 7'd0, 6'd0, 1'b0, '0);
    plan(REQ_PRINT, NEWLINE_CODE, 7'd0, 6'd0, 1'b0, '0);
    plan(REQ_PRINT, 8'hFF, 7'd0, 6'd0, 1'b0, '0);
    plan(REQ_SET, 8'h00, 7'd0, 6'd0, 1'b1, {STATUS_OK, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_PRINT, 8'h80, 7'd0, 6'd0, 1'b0, '0);
    plan(REQ_PRINT, 8'h7F, 7'd0, 6'd0, 1'b0, '0);
    plan(REQ_READ, 8'h00, 7'd0, 6'd0, 1'b0, '0);
    plan(REQ_SCROLL, 8'h00, 7'd0, 6'd0, 1'b0, '0);
    plan(REQ_READ, 8'h00, 7'd0, 6'd29, 1'b0, '0);
    plan(REQ_CLEAR, 8'h00, 7'd0, 6'd0, 1'b1, {STATUS_OK, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_READ, 8'h00, 7'd79, 6'd29, 1'b1, {STATUS_OK, 8'h00, ATTR_RST, 7'd0, 6'd0});
    plan(REQ_UNKNOWN_LO, 8'hFF, 7'd127, 6'd63, 1'b1, {STATUS_OK, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_W'(6), 8'h55, 7'd42, 6'd21, 1'b1, {STATUS_OK, 8'h00, 8'h00, 7'd0, 6'd0});
    plan(REQ_UNKNOWN_HI, 8'h00, 7'd0, 6'd0, 1'b1, {STATUS_OK, 8'h00, 8'h00, 7'd0, 6'd0});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain_results();

    foreach (boot_plan[i]) send(boot_plan[i], 0);
    start <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_reg(CFG_COLUMNS, CFG_DATA_W'(ph_cols[p]));
      write_reg(CFG_ROWS, CFG_DATA_W'(ph_rows[p]));
      write_reg(CFG_ATTR, CFG_DATA_W'(ph_attr[p]));
      cfg_we <= 1'b0;
      @(negedge clk);
      for (int k = 0; k < ph_items[p]; k++) send(pick_cmd(ph_sweep[p]), ph_idle[p]);
      start <= 1'b0;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (due_results.size() != 0) begin
      n_fail += due_results.size();
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end

    $display("console run: %0d requests over %0d window settings, %0d clears and scrolls",
             n_sent, PHASES + 1, n_sweeps);
    $display("console run: %0d results compared, %0d mismatches", n_checked, n_fail);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
